// ----- rtl/etfi_pkg.sv -----
`default_nettype none

package etfi_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_FRACTAL_MODE     = 3'd0,
		CFG_ITERATION_LIMIT  = 3'd1,
		CFG_JULIA_CONST_REAL = 3'd2,
		CFG_JULIA_CONST_IMAG = 3'd3,
		CFG_MANDEL_RADIUS_SQ = 3'd4,
		CFG_JULIA_RADIUS_SQ  = 3'd5
	} cfg_index_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned COORD_W     = 32;
	localparam int unsigned RADIUS_W    = 31;
	localparam int unsigned LIMIT_W     = 16;
	localparam int unsigned COUNT_W     = 16;

	localparam logic                       MODE_MANDEL    = 1'b0;
	localparam logic                       MODE_JULIA     = 1'b1;
	localparam logic [LIMIT_W-1:0]         LIMIT_RST      = 16'd256;
	localparam logic signed [COORD_W-1:0]  JULIA_RE_RST   = 32'shF999999A;
	localparam logic signed [COORD_W-1:0]  JULIA_IM_RST   = 32'sh0999999A;
	localparam logic [RADIUS_W-1:0]        MANDEL_RAD_RST = 31'h033D70A4;
	localparam logic [RADIUS_W-1:0]        JULIA_RAD_RST  = 31'h40000000;

	localparam logic signed [2*COORD_W-1:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [2*COORD_W-1:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_real;
		logic signed [COORD_W-1:0] point_imag;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] escape_count;
		logic               escaped;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
	} etfi_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL
	} etfi_state_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [2*COORD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[COORD_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/etfi_dpath.sv -----
`default_nettype none

module etfi_dpath import etfi_pkg::*; #(
	parameter int unsigned FRAC_BITS = 28
) (
	input  wire logic                       clk,
	input  wire etfi_cmd_t                  cmd,
	input  wire in_item_t                   point,
	input  wire logic                       fractal_mode,
	input  wire logic signed [COORD_W-1:0]  julia_const_real,
	input  wire logic signed [COORD_W-1:0]  julia_const_imag,
	input  wire logic [RADIUS_W-1:0]        mandel_radius_sq,
	input  wire logic [RADIUS_W-1:0]        julia_radius_sq,
	output logic                            escape
);

	localparam int unsigned PROD_W = 2 * COORD_W;
	localparam int unsigned CMP_W  = (RADIUS_W + FRAC_BITS > PROD_W) ?
		RADIUS_W + FRAC_BITS : PROD_W;

	logic signed [COORD_W-1:0] z_real_q, z_imag_q;
	logic signed [COORD_W-1:0] k_real_q, k_imag_q;
	logic [RADIUS_W-1:0]       radius_q;

	logic signed [PROD_W-1:0]  prod_rr_s1, prod_ii_s1, prod_ri_s1;

	logic signed [PROD_W-1:0]  diff;
	logic signed [PROD_W-1:0]  re_sum, im_sum;
	logic [PROD_W-1:0]         mag;
	logic [CMP_W-1:0]          mag_ext, bound;

	// Iterate state and per-item constants
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (fractal_mode == MODE_JULIA) begin
				z_real_q <= point.point_real;
				z_imag_q <= point.point_imag;
				k_real_q <= julia_const_real;
				k_imag_q <= julia_const_imag;
				radius_q <= julia_radius_sq;
			end else begin
				z_real_q <= '0;
				z_imag_q <= '0;
				k_real_q <= point.point_real;
				k_imag_q <= point.point_imag;
				radius_q <= mandel_radius_sq;
			end
		end else if (cmd.upd) begin
			z_real_q <= sat32(re_sum);
			z_imag_q <= sat32(im_sum);
		end
	end

	// Square terms of the current z
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_rr_s1 <= PROD_W'(z_real_q) * PROD_W'(z_real_q);
			prod_ii_s1 <= PROD_W'(z_imag_q) * PROD_W'(z_imag_q);
			prod_ri_s1 <= PROD_W'(z_real_q) * PROD_W'(z_imag_q);
		end
	end

	always_comb begin
		diff   = prod_rr_s1 - prod_ii_s1;
		re_sum = (diff >>> FRAC_BITS) + PROD_W'(k_real_q);
		im_sum = (prod_ri_s1 >>> (FRAC_BITS - 1)) + PROD_W'(k_imag_q);
		// |z|^2 of the z that the products were taken from
		mag     = $unsigned(prod_rr_s1) + $unsigned(prod_ii_s1);
		mag_ext = CMP_W'(mag);
		bound   = CMP_W'(radius_q) << FRAC_BITS;
		escape  = mag_ext > bound;
	end

endmodule

`default_nettype wire

// ----- rtl/etfi_ctrl.sv -----
`default_nettype none

module etfi_ctrl import etfi_pkg::*; #(
	parameter int unsigned ITER_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [LIMIT_W-1:0] iteration_limit,
	input  wire logic               escape,
	input  wire logic               out_free,
	output etfi_cmd_t               cmd,
	output logic                    busy,
	output logic                    done,
	output out_item_t               result
);

	etfi_state_t           state_q, state_d;
	logic [ITER_WIDTH-1:0] iter_q, iter_m1, limit;
	logic                  iter_clr, iter_inc;
	logic                  hit, finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (iter_clr) begin
				iter_q <= '0;
			end else if (iter_inc) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_comb begin
		limit   = ITER_WIDTH'(iteration_limit);
		iter_m1 = iter_q - 1'b1;
		// an escape only counts once z has been updated at least once
		hit     = (iter_q != '0) && escape;
		finish  = hit || (iter_q == limit);
		result.escaped      = hit;
		result.escape_count = hit ? COUNT_W'(iter_m1) : '0;
		busy     = (state_q != ST_IDLE);
		state_d  = state_q;
		cmd      = '0;
		iter_clr = 1'b0;
		iter_inc = 1'b0;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					iter_clr = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (finish) begin
					if (out_free) begin
						done    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.upd  = 1'b1;
					iter_inc = 1'b1;
					state_d  = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/escape_time_fractal_iterator_top.sv -----
`default_nettype none

// Escape-time fractal iterator. Each input transfer carries one complex point in
// signed Q4.28; the block runs z = z*z + k (Mandelbrot: z from 0, k = point;
// Julia: z = point, k = configured constant) and returns one result per point:
// the 0-based index of the first iteration whose |z|^2 exceeds the mode's
// squared radius, or 0 with escaped low once iteration_limit iterations pass.
// One point is worked at a time. Each iteration takes a step through the three
// 32x32 square-term multipliers and then one for the update and the exact
// |z|^2 compare, since the next z feeds back through the multiplier registers.
// A result is loaded into the output register once its point ends and that
// register is free (the default iteration_limit is 256); the next point is
// taken the cycle after. Since the result sits in that output register, a new
// point may be taken while the previous result still waits for its transfer.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// made while the block is idle; an index beyond the register list is dropped.

module escape_time_fractal_iterator_top import etfi_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 28,
	parameter int unsigned ITER_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_item,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_item,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic                      fractal_mode_q;
	logic [LIMIT_W-1:0]        iteration_limit_q;
	logic signed [COORD_W-1:0] julia_const_real_q;
	logic signed [COORD_W-1:0] julia_const_imag_q;
	logic [RADIUS_W-1:0]       mandel_radius_sq_q;
	logic [RADIUS_W-1:0]       julia_radius_sq_q;

	etfi_cmd_t cmd;
	logic      escape;
	logic      busy;
	logic      done;
	logic      start;
	logic      out_free;
	out_item_t result;

	// output register
	logic      out_valid_q;
	out_item_t out_item_q;

	assign cfg_ready = 1'b1;

	// Take a write for any index; codes past the list fall to the default arm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fractal_mode_q     <= MODE_MANDEL;
			iteration_limit_q  <= LIMIT_RST;
			julia_const_real_q <= JULIA_RE_RST;
			julia_const_imag_q <= JULIA_IM_RST;
			mandel_radius_sq_q <= MANDEL_RAD_RST;
			julia_radius_sq_q  <= JULIA_RAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_FRACTAL_MODE:     fractal_mode_q     <= cfg_data[0];
				CFG_ITERATION_LIMIT:  iteration_limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_JULIA_CONST_REAL: julia_const_real_q <= cfg_data[COORD_W-1:0];
				CFG_JULIA_CONST_IMAG: julia_const_imag_q <= cfg_data[COORD_W-1:0];
				CFG_MANDEL_RADIUS_SQ: mandel_radius_sq_q <= cfg_data[RADIUS_W-1:0];
				CFG_JULIA_RADIUS_SQ:  julia_radius_sq_q  <= cfg_data[RADIUS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold off new points while one is being iterated.
	assign in_stall = busy;
	assign start    = in_valid && !in_stall;

	// The register can take a new result when empty or draining this cycle.
	assign out_free = !out_valid_q || !out_stall;

	etfi_ctrl #(
		.ITER_WIDTH (ITER_WIDTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.iteration_limit (iteration_limit_q),
		.escape          (escape),
		.out_free        (out_free),
		.cmd             (cmd),
		.busy            (busy),
		.done            (done),
		.result          (result)
	);

	etfi_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk              (clk),
		.cmd              (cmd),
		.point            (in_item),
		.fractal_mode     (fractal_mode_q),
		.julia_const_real (julia_const_real_q),
		.julia_const_imag (julia_const_imag_q),
		.mandel_radius_sq (mandel_radius_sq_q),
		.julia_radius_sq  (julia_radius_sq_q),
		.escape           (escape)
	);

	// Load a finished result; drop the valid once its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	// An accepted point keeps the input side stalled on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("input not stalled after a point transfer");

	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// A point that did not escape reports a zero count.
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.escaped || out_item_q.escape_count == '0))
		else $error("non-escaped result with nonzero count");

	// Results only appear from a point that was iterated.
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result produced while idle");
`endif

endmodule

`default_nettype wire
